[rtl/core/recorded_route_playback_follower_unit_defines.svh]
// Assertion macros for the route playback follower.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RECORDED_ROUTE_PLAYBACK_FOLLOWER_UNIT_DEFINES_SVH
`define RECORDED_ROUTE_PLAYBACK_FOLLOWER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RRPF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("rrpf: assertion failed");
`define RRPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rrpf: assertion failed");
`else
`define RRPF_ASSERT(lbl, clk, rstn, prop)
`define RRPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/rrpf_pkg.sv]
// Shared types, constants and helper functions of the route playback follower.
// No dependencies.
package rrpf_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int TRACE_DEPTH = 1024;

    localparam int LANES   = 4;      // speed/encoder lanes on the ports
    localparam int LANE_W  = 2;
    localparam int LCNT_W  = 3;

    localparam int PTR_W   = $clog2(TRACE_DEPTH);
    localparam int LEN_W   = PTR_W + 1;
    localparam int ADDR_W  = $clog2(MOTOR_COUNT * TRACE_DEPTH);
    localparam int POS_W   = 32;
    localparam int SPD_W   = 16;
    localparam int TS_W    = 15;
    localparam int TOL_W   = 16;
    localparam int DIST_W  = 32;
    localparam int QUO_W   = TS_W;
    localparam int PROD_W  = TS_W + DIST_W;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [TS_W-1:0]  TS_RESET  = TS_W'(1000);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(20);

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH_TOL    = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_W_PREV,
        S_W_CUR,
        S_W_EVAL,
        S_UPD,
        S_T_RD,
        S_T_CAP,
        S_MUL,
        S_DIVGO,
        S_DIVW,
        S_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // point counts as reached when past it in its direction or within tolerance
    function automatic logic reached(input logic signed [POS_W-1:0] pos,
                                     input logic signed [POS_W-1:0] fin,
                                     input logic back,
                                     input logic [TOL_W-1:0] tol);
        logic signed [POS_W:0] d;
        logic [POS_W:0] mag;
        d = $signed({pos[POS_W-1], pos}) - $signed({fin[POS_W-1], fin});
        mag = d[POS_W] ? (POS_W+1)'(-d) : (POS_W+1)'(d);
        return (back ? (pos <= fin) : (pos >= fin)) ||
               (mag < (POS_W+1)'(tol));
    endfunction

    function automatic logic [ADDR_W-1:0] trace_addr(input logic [LANE_W-1:0] motor,
                                                     input logic [PTR_W-1:0] idx);
        return ADDR_W'(ADDR_W'(motor) * ADDR_W'(TRACE_DEPTH) + ADDR_W'(idx));
    endfunction

endpackage

[rtl/core/recorded_route_playback_follower_unit.sv]
// Top level of the route playback follower: sequencer, state and stream ports.
// Depends on rrpf_pkg, rrpf_trace_ram, rrpf_divider and the macro header.
//
// A tick while playing walks the trace memory one point per cycle for each motor,
// then fetches the targets, then per moving motor does one multiply and a run of
// the shared 15-step divider. The block takes no new input word until the result
// of the current one is in the output register. Trace memory has no reset; read
// only points that were loaded.
`include "recorded_route_playback_follower_unit_defines.svh"
module recorded_route_playback_follower_unit
    import rrpf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // motor_select, point_index, point_value, route_length,
    // encoder_zero, encoder_one, encoder_two, encoder_three
    input  logic [183:0]         s_tdata,
    // command
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // speed_zero, speed_one, speed_two, speed_three, point_position
    output logic [79:0]          m_tdata,
    // finished, playing
    output logic [1:0]           m_tuser
);

    state_t state_reg, state_next;

    logic [TS_W-1:0]   ts_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              play_reg;
    logic              fin_reg;

    logic [POS_W-1:0]  enc_reg  [LANES];
    logic [DIST_W-1:0] dist_reg [LANES];
    logic              neg_reg  [LANES];
    logic              blk_reg  [LANES];
    logic [SPD_W-1:0]  spd_reg  [LANES];

    logic [LCNT_W-1:0] m_reg;
    logic [PTR_W-1:0]  k_reg;
    logic [LEN_W-1:0]  next_reg;
    logic              done_reg;
    logic [POS_W-1:0]  prev_reg;
    logic [DIST_W-1:0] maxd_reg;
    logic [PROD_W-1:0] prod_reg;

    logic              m_valid_reg;
    logic [79:0]       m_data_reg;
    logic [1:0]        m_user_reg;

    logic              s_acc;
    cmd_t              cmd_in;
    logic [1:0]        ms_in;
    logic [9:0]        pi_in;
    logic [10:0]       len_in;
    logic [LEN_W-1:0]  last;
    logic              last_motor;
    logic [LANE_W-1:0] lane;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [POS_W-1:0]  ram_rdata;

    logic              walk_hit;
    logic signed [POS_W:0] tdiff;
    logic [POS_W:0]    tmag;

    logic              div_start;
    logic [QUO_W-1:0]  div_quo;
    div_stat_t         div_stat;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign cmd_in     = cmd_t'(s_tuser);
    assign ms_in      = s_tdata[1:0];
    assign pi_in      = s_tdata[11:2];
    assign len_in     = s_tdata[54:44];
    assign last       = len_reg - LEN_W'(1);
    assign lane       = m_reg[LANE_W-1:0];
    assign last_motor = (m_reg == LCNT_W'(MOTOR_COUNT - 1));

    assign ram_we    = s_acc && (cmd_in == CMD_LOAD) &&
                       (32'(ms_in) < MOTOR_COUNT) && (32'(pi_in) < TRACE_DEPTH);
    assign ram_waddr = trace_addr(ms_in, PTR_W'(pi_in));

    rrpf_trace_ram #(
        .DATA_W(POS_W),
        .DEPTH (MOTOR_COUNT * TRACE_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(s_tdata[43:12]),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    rrpf_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .numer  (prod_reg),
        .denom  (maxd_reg),
        .quo    (div_quo),
        .stat   (div_stat)
    );

    always_comb begin
        // direction into point k comes from the step from point k-1
        walk_hit = reached(enc_reg[lane], ram_rdata,
                           $signed(ram_rdata) < $signed(prev_reg), tol_reg);
        tdiff = $signed({ram_rdata[POS_W-1], ram_rdata}) -
                $signed({enc_reg[lane][POS_W-1], enc_reg[lane]});
        tmag  = tdiff[POS_W] ? (POS_W+1)'(-tdiff) : (POS_W+1)'(tdiff);
    end

    always_comb begin
        state_next = state_reg;
        ram_raddr  = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    state_next = (cmd_in == CMD_TICK && play_reg) ? S_W_PREV : S_FIN;
                end
            end
            S_W_PREV: begin
                ram_raddr  = trace_addr(lane, (ptr_reg == '0) ? '0 : ptr_reg - PTR_W'(1));
                state_next = S_W_CUR;
            end
            S_W_CUR: begin
                ram_raddr  = trace_addr(lane, ptr_reg);
                state_next = S_W_EVAL;
            end
            S_W_EVAL: begin
                ram_raddr = trace_addr(lane, k_reg + PTR_W'(1));
                if (!(LEN_W'(k_reg) < last && walk_hit)) begin
                    state_next = last_motor ? S_UPD : S_W_PREV;
                end
            end
            S_UPD: begin
                state_next = done_reg ? S_FIN : S_T_RD;
            end
            S_T_RD: begin
                ram_raddr  = trace_addr(lane, ptr_reg);
                state_next = S_T_CAP;
            end
            S_T_CAP: begin
                state_next = last_motor ? S_MUL : S_T_RD;
            end
            S_MUL: begin
                if (blk_reg[lane]) begin
                    state_next = last_motor ? S_FIN : S_MUL;
                end else begin
                    state_next = S_DIVGO;
                end
            end
            S_DIVGO: begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (div_stat.done) begin
                    state_next = last_motor ? S_FIN : S_MUL;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg      <= TS_RESET;
            tol_reg     <= TOL_RESET;
            ptr_reg     <= '0;
            len_reg     <= LEN_W'(1);
            play_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TARGET_SPEED: ts_reg  <= cfg_wdata[TS_W-1:0];
                    CFG_REACH_TOL:    tol_reg <= cfg_wdata[TOL_W-1:0];
                    default: ;
                endcase
            end
            // the result load below takes over in S_FIN
            if (m_valid_reg && m_tready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        fin_reg    <= 1'b0;
                        m_reg      <= '0;
                        k_reg      <= ptr_reg;
                        next_reg   <= len_reg;
                        done_reg   <= (LEN_W'(ptr_reg) == last);
                        enc_reg[0] <= s_tdata[86:55];
                        enc_reg[1] <= s_tdata[118:87];
                        enc_reg[2] <= s_tdata[150:119];
                        enc_reg[3] <= s_tdata[182:151];
                        for (int i = 0; i < LANES; i++) begin
                            spd_reg[i] <= '0;
                        end
                        if (cmd_in == CMD_START) begin
                            if (len_in == '0) begin
                                len_reg <= LEN_W'(1);
                            end else if (32'(len_in) > TRACE_DEPTH) begin
                                len_reg <= LEN_W'(TRACE_DEPTH);
                            end else begin
                                len_reg <= LEN_W'(len_in);
                            end
                            ptr_reg  <= '0;
                            play_reg <= 1'b1;
                        end
                    end
                end
                S_W_PREV: ;
                S_W_CUR: begin
                    prev_reg <= ram_rdata;
                end
                S_W_EVAL: begin
                    if (k_reg == ptr_reg && done_reg) begin
                        done_reg <= walk_hit;
                    end
                    if (LEN_W'(k_reg) < last && walk_hit) begin
                        prev_reg <= ram_rdata;
                        k_reg    <= k_reg + PTR_W'(1);
                    end else begin
                        if (LEN_W'(k_reg) < next_reg) begin
                            next_reg <= LEN_W'(k_reg);
                        end
                        k_reg <= ptr_reg;
                        m_reg <= last_motor ? '0 : m_reg + LCNT_W'(1);
                    end
                end
                S_UPD: begin
                    ptr_reg  <= (next_reg < last) ? next_reg[PTR_W-1:0] : last[PTR_W-1:0];
                    maxd_reg <= DIST_W'(1);
                    if (done_reg) begin
                        play_reg <= 1'b0;
                        fin_reg  <= 1'b1;
                    end
                end
                S_T_RD: ;
                S_T_CAP: begin
                    // reached at the target collapses to exact hit or within tolerance
                    dist_reg[lane] <= tmag[DIST_W-1:0];
                    neg_reg[lane]  <= tdiff[POS_W];
                    blk_reg[lane]  <= (tdiff == '0) || (tmag < (POS_W+1)'(tol_reg));
                    if (!((tdiff == '0) || (tmag < (POS_W+1)'(tol_reg))) &&
                        tmag[DIST_W-1:0] >= maxd_reg) begin
                        maxd_reg <= tmag[DIST_W-1:0];
                    end
                    m_reg <= last_motor ? '0 : m_reg + LCNT_W'(1);
                end
                S_MUL: begin
                    if (blk_reg[lane]) begin
                        m_reg <= m_reg + LCNT_W'(1);
                    end else begin
                        prod_reg <= PROD_W'(ts_reg) * PROD_W'(dist_reg[lane]);
                    end
                end
                S_DIVGO: ;
                S_DIVW: begin
                    if (div_stat.done) begin
                        spd_reg[lane] <= neg_reg[lane] ? SPD_W'(-{1'b0, div_quo})
                                                       : SPD_W'({1'b0, div_quo});
                        m_reg <= m_reg + LCNT_W'(1);
                    end
                end
                S_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {6'd0, 10'(ptr_reg), spd_reg[3], spd_reg[2],
                                        spd_reg[1], spd_reg[0]};
                        m_user_reg  <= {play_reg, fin_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `RRPF_ASSERT(a_fin_stops, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> !m_tuser[1])
    `RRPF_ASSERT(a_fin_still, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tdata[63:0] == '0))
    `RRPF_ASSERT(a_ptr_range, aclk, aresetn, LEN_W'(ptr_reg) < len_reg)

endmodule

[rtl/core/rrpf_trace_ram.sv]
// Trace point memory: one write port, one registered read port.
// Generic; no package dependencies.
module rrpf_trace_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/rrpf_divider.sv]
// Restoring divider, one quotient bit per cycle, for the speed scaling.
// Depends on rrpf_pkg and the assertion macro header.
`include "recorded_route_playback_follower_unit_defines.svh"
module rrpf_divider
    import rrpf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [PROD_W-1:0] numer,
    input  logic [DIST_W-1:0] denom,
    output logic [QUO_W-1:0]  quo,
    output div_stat_t         stat
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DIST_W-1:0] rem_reg;
    logic [DIST_W-1:0] den_reg;
    logic [QUO_W-1:0]  num_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIST_W:0]   trial;
    logic              qbit;

    always_comb begin
        trial = {rem_reg, num_reg[QUO_W-1]};
        qbit  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                // quotient fits QUO_W bits, so the top part is already below denom
                rem_reg  <= numer[PROD_W-1:QUO_W];
                num_reg  <= numer[QUO_W-1:0];
                den_reg  <= denom;
                cnt_reg  <= CNT_W'(QUO_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= qbit ? DIST_W'(trial - {1'b0, den_reg}) : trial[DIST_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], qbit};
                num_reg <= {num_reg[QUO_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `RRPF_ASSERT(a_start_idle, aclk, aresetn, start |-> !busy_reg)
    `RRPF_ASSERT(a_busy_cnt, aclk, aresetn, busy_reg |-> (cnt_reg != '0))
    `RRPF_ASSERT_NEXT(a_done_once, aclk, aresetn, done_reg, !done_reg)

endmodule

[bench/tb_recorded_route_playback_follower_unit.sv]
// Testbench for recorded_route_playback_follower_unit: drives load, start, tick and
// unknown words and checks each result against a predictor kept in the bench.
// Depends on rrpf_pkg and the RTL of the block.
`timescale 1ns / 100ps
module tb_recorded_route_playback_follower_unit;
    import rrpf_pkg::*;

    localparam int CYCLE_LIMIT = 40000000;

    typedef struct packed {
        cmd_t              cmd;
        logic [1:0]        motor;
        logic [9:0]        index;
        logic [31:0]       value;
        logic [10:0]       length;
        logic [3:0][31:0]  enc;
    } route_word_t;

    typedef struct packed {
        logic [3:0][15:0] speed;
        logic [9:0]       position;
        logic             finished;
        logic             playing;
    } follow_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic [1:0]   m_tuser;

    recorded_route_playback_follower_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    int              trace_pts [4][TRACE_DEPTH];
    int unsigned     pred_point;
    int unsigned     pred_length;
    bit              pred_playing;
    int unsigned     pred_speed_cfg;
    int unsigned     pred_tol_cfg;
    follow_result_t  pending_results[$];

    string speed_names [4] = '{"speed_zero", "speed_one", "speed_two", "speed_three"};

    int  error_count = 0;
    int  words_sent = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;
    int  stall_left = 0;

    function automatic bit point_reached(longint pos, longint fin, bit back);
        longint d;
        d = pos - fin;
        if (d < 0) d = -d;
        return (!back && pos >= fin) || (back && pos <= fin) || (d < longint'(pred_tol_cfg));
    endfunction

    function automatic bit route_falls(int m, int unsigned from, int unsigned to);
        return longint'(trace_pts[m][to]) - longint'(trace_pts[m][from]) < 0;
    endfunction

    function automatic follow_result_t follow_step(route_word_t w);
        follow_result_t r;
        int unsigned last, ptr, nxt, k, len;
        bit done, back;
        longint enc [4];
        longint tgt, d;
        longint unsigned span [4];
        longint unsigned maxd, v;
        bit blocked [4];
        r = '0;
        for (int m = 0; m < 4; m++) enc[m] = longint'($signed(w.enc[m]));
        if (w.cmd == CMD_LOAD) begin
            trace_pts[w.motor][w.index] = w.value;
        end else if (w.cmd == CMD_START) begin
            len = w.length;
            if (len < 1) len = 1;
            if (len > TRACE_DEPTH) len = TRACE_DEPTH;
            pred_length = len;
            pred_point = 0;
            pred_playing = 1'b1;
        end else if (w.cmd == CMD_TICK && pred_playing) begin
            last = pred_length - 1;
            ptr = pred_point;
            done = (ptr == last);
            nxt = pred_length;
            for (int m = 0; m < 4; m++) begin
                k = ptr;
                back = route_falls(m, ptr ? ptr - 1 : 0, ptr);
                if (done) done = point_reached(enc[m], trace_pts[m][ptr], back);
                while (k < last && point_reached(enc[m], trace_pts[m][k],
                                                 route_falls(m, k ? k - 1 : 0, k)))
                    k++;
                if (k < nxt) nxt = k;
            end
            pred_point = nxt < last ? nxt : last;
            if (done) begin
                pred_playing = 1'b0;
                r.finished = 1'b1;
            end else begin
                maxd = 1;
                for (int m = 0; m < 4; m++) begin
                    tgt = trace_pts[m][pred_point];
                    d = tgt - enc[m];
                    blocked[m] = point_reached(enc[m], tgt, d < 0);
                    span[m] = d < 0 ? -d : d;
                    if (!blocked[m] && span[m] >= maxd) maxd = span[m];
                end
                for (int m = 0; m < 4; m++) begin
                    if (!blocked[m]) begin
                        v = (64'(pred_speed_cfg) * span[m]) / maxd;
                        if (longint'(trace_pts[m][pred_point]) - enc[m] < 0) v = -v;
                        r.speed[m] = v[15:0];
                    end
                end
            end
        end
        r.position = pred_point[9:0];
        r.playing = pred_playing;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!idle_on || p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic route_word_t noise_word(cmd_t c);
        route_word_t w;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(route_word_t)-1:0];
        w.cmd = c;
        return w;
    endfunction

    task automatic send_word(route_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= w.cmd;
        s_tdata <= {1'b0, w.enc, w.length, w.value, w.index, w.motor};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(follow_step(w));
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_TARGET_SPEED) pred_speed_cfg = val & 32'h7FFF;
        else pred_tol_cfg = val & 32'hFFFF;
    endtask

    task automatic load_point(int m, int i, int val);
        route_word_t w;
        w = noise_word(CMD_LOAD);
        w.motor = m;
        w.index = i;
        w.value = val;
        send_word(w);
    endtask

    // random walk per motor; occasionally the walk jumps to the extremes
    task automatic load_route(int unsigned len);
        int val;
        for (int m = 0; m < 4; m++) begin
            val = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000) - 10000;
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0: val = 32'h7FFF_FFFF;
                    1: val = 32'h8000_0000;
                    2: val = val;
                    default: val = val + $urandom_range(0, 4000) - 2000;
                endcase
                load_point(m, i, val);
            end
        end
    endtask

    task automatic start_route(int unsigned raw_len);
        route_word_t w;
        w = noise_word(CMD_START);
        w.length = raw_len;
        send_word(w);
    endtask

    function automatic int near_count(int m);
        int unsigned i;
        int base;
        i = pred_point + $urandom_range(0, 2);
        if (i >= pred_length) i = pred_length - 1;
        base = trace_pts[m][i];
        case ($urandom_range(0, 7))
            0: return base;
            1: return base + $urandom_range(0, 2 * pred_tol_cfg + 2) - pred_tol_cfg - 1;
            2: return $urandom;
            3: return base + $urandom_range(0, 10000) - 5000;
            default: return base + $urandom_range(0, 600) - 300;
        endcase
    endfunction

    task automatic tick_route();
        route_word_t w;
        w = noise_word(CMD_TICK);
        if (pred_playing && $urandom_range(0, 9) != 0)
            for (int m = 0; m < 4; m++) w.enc[m] = near_count(m);
        send_word(w);
    endtask

    task automatic tick_at(int unsigned i);
        route_word_t w;
        w = noise_word(CMD_TICK);
        for (int m = 0; m < 4; m++) w.enc[m] = trace_pts[m][i];
        send_word(w);
    endtask

    // monitor and scoreboard
    always @(posedge aclk) begin
        follow_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.speed = m_tdata[63:0];
            got.position = m_tdata[73:64];
            got.finished = m_tuser[0];
            got.playing = m_tuser[1];
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                for (int m = 0; m < 4; m++)
                    if (got.speed[m] !== want.speed[m]) begin
                        $error("%s exp %0d got %0d", speed_names[m],
                               $signed(want.speed[m]), $signed(got.speed[m]));
                        error_count++;
                    end
                if (got.position !== want.position) begin
                    $error("point_position exp %0d got %0d", want.position, got.position);
                    error_count++;
                end
                if (got.finished !== want.finished) begin
                    $error("finished exp %0d got %0d", want.finished, got.finished);
                    error_count++;
                end
                if (got.playing !== want.playing) begin
                    $error("playing exp %0d got %0d", want.playing, got.playing);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 2) == 0)
                stall_left <= $urandom_range(0, 9) == 0 ? $urandom_range(10, 60)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_idle_words();
        route_word_t w;
        send_word(noise_word(CMD_TICK));
        send_word(noise_word(CMD_NONE));
        w = noise_word(CMD_NONE);
        w.enc = '1;
        send_word(w);
    endtask

    // full trace store, length saturation at the top, jump to the end in one tick
    task automatic test_long_route();
        idle_on = 1'b0;
        for (int m = 0; m < 4; m++)
            for (int i = 0; i < TRACE_DEPTH; i++)
                load_point(m, i, (m == 3 && i == TRACE_DEPTH - 1) ? 32'h7FFF_FFFF
                                 : -2147483647 + i * 2000 + m);
        idle_on = 1'b1;
        start_route(11'h7FF);
        tick_at(TRACE_DEPTH - 1);
        tick_at(TRACE_DEPTH - 1);
        tick_route();
    endtask

    task automatic test_short_directed();
        load_route(3);
        start_route(0);
        tick_at(1);
        tick_at(0);
        start_route(3);
        tick_at(0);
        tick_at(1);
        tick_at(2);
        start_route(2);
        send_word(noise_word(CMD_NONE));
        tick_route();
    endtask

    task automatic test_config_extremes();
        int unsigned spd [4] = '{0, 32767, 1, 1000};
        int unsigned tol [4] = '{0, 65535, 1, 20};
        for (int s = 0; s < 4; s++) begin
            write_reg(CFG_TARGET_SPEED, spd[s]);
            write_reg(CFG_REACH_TOL, tol[s]);
            load_route(4);
            start_route(4);
            repeat (6) tick_route();
        end
    endtask

    task automatic test_random_routes();
        int unsigned len;
        while (words_sent < 1200 + 4 * TRACE_DEPTH) begin
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_TARGET_SPEED, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32767));
                write_reg(CFG_REACH_TOL, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300));
            end
            idle_on = $urandom_range(0, 4) != 0;
            len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 8);
            if (len <= 8) load_route(len == 0 ? 1 : len);
            start_route(len);
            repeat ($urandom_range(4, 14)) begin
                if ($urandom_range(0, 19) == 0) send_word(noise_word(CMD_NONE));
                tick_route();
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        pred_point = 0;
        pred_length = 1;
        pred_playing = 1'b0;
        pred_speed_cfg = 1000;
        pred_tol_cfg = 20;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_words();
        test_long_route();
        test_short_directed();
        test_config_extremes();
        test_random_routes();
        wait_drained();
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
